// ===== rtl/assert_macros.svh =====
// Assertion helpers for checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication with asynchronous reset disable.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Clocked next-cycle implication with asynchronous reset disable.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/rmts_pkg.sv =====
package rmts_pkg;

    localparam int unsigned ID_W     = 22;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned DL_W     = 32;
    localparam int unsigned UTIL_W   = 10;
    localparam int unsigned STATUS_W = 3;

    localparam logic [UTIL_W-1:0] UTIL_LIMIT_RESET = 10'd693;
    localparam logic [UTIL_W-1:0] UTIL_SCALE       = 10'd1000;

    typedef enum logic [1:0] {
        REQ_REGISTER   = 2'd0,
        REQ_YIELD      = 2'd1,
        REQ_DEREGISTER = 2'd2,
        REQ_TICK       = 2'd3
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK          = 3'd0,
        STATUS_REFUSED     = 3'd1,
        STATUS_TABLE_FULL  = 3'd2,
        STATUS_NOT_FOUND   = 3'd3,
        STATUS_ZERO_PERIOD = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        RUN_READY    = 2'd0,
        RUN_RUNNING  = 2'd1,
        RUN_SLEEPING = 2'd2
    } run_state_t;

    typedef struct packed {
        logic [ID_W-1:0]     task_id;
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] runtime;
        logic [DL_W-1:0]     deadline;
        logic [1:0]          run_state;
    } slot_t;

endpackage

// ===== rtl/rate_monotonic_task_scheduler.sv =====
// Rate-monotonic task scheduler with utilization admission. One request item is taken at a
// time and answered with one result item, and the next request is accepted only after that
// result has been taken. The task table lives in a synchronous memory that is walked one slot
// at a time, with a read state and an evaluate state per slot. A tick that wakes no task, or
// a yield for an unknown id, goes from the walk straight to the result. A yield, or a tick
// that wakes a task, walks the table a second time to find the shortest ready or running
// period and then rewrites the old running entry, if there is one, and the new one.
// Register runs a 26-step restoring divider for 1000*runtime/period, and skips it for a zero
// period. Deregister walks the table like a tick and divides again for each slot it removes.
module rate_monotonic_task_scheduler
    import rmts_pkg::*;
#(
    parameter int unsigned MAX_TASKS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from the lowest bit: task_id, period, run_time.
    input  logic [55:0] s_tdata,
    // Fields from the lowest bit: req_type.
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from the lowest bit: status, running_valid, running_id,
    // utilization_total.
    output logic [39:0] m_tdata
);

    localparam int unsigned IDX_W = $clog2(MAX_TASKS);
    localparam int unsigned NUM_W = 26;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_READ, S_EVAL, S_DIV, S_DIVDONE, S_DREAD, S_DEVAL,
        S_DEMRD, S_DEMWR, S_PRORD, S_PROWR, S_RREAD, S_RESULT
    } state_t;

    slot_t mem [MAX_TASKS];
    slot_t rd_data;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_t            wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    state_t state_reg;
    logic [MAX_TASKS-1:0] used_reg, dlset_reg;
    logic [DL_W-1:0]      time_reg;
    logic [UTIL_W-1:0]    util_reg, limit_reg;
    logic                 run_p_reg;
    logic [IDX_W-1:0]     run_slot_reg;
    logic [1:0]           kind_reg;
    logic [ID_W-1:0]      id_reg;
    logic [PERIOD_W-1:0]  per_reg, rt_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 found_reg, woke_reg, best_v_reg;
    logic [IDX_W-1:0]     best_reg;
    logic [PERIOD_W-1:0]  best_per_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [PERIOD_W:0]    rem_reg;
    logic [PERIOD_W-1:0]  den_reg;
    logic [4:0]           dcnt_reg;
    logic                 m_valid_reg;
    logic [39:0]          m_data_reg;

    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  free_idx;
    logic [PERIOD_W:0] trial;
    logic [UTIL_W:0]   share;
    logic              share_big;
    logic [UTIL_W+1:0] sum_ext;
    logic              admit;
    logic [DL_W-1:0]   new_dl;
    logic              hit;

    assign idx       = idx_reg;
    assign trial     = {rem_reg[PERIOD_W-1:0], num_reg[NUM_W-1]} - {1'b0, den_reg};
    assign share     = num_reg[UTIL_W:0];
    assign share_big = |num_reg[NUM_W-1:UTIL_W+1];
    assign sum_ext   = {2'b00, util_reg} + {1'b0, share};
    assign admit     = !share_big && (sum_ext <= {2'b00, limit_reg}) && !(&used_reg);
    assign hit       = used_reg[idx] && (rd_data.task_id == id_reg);
    assign new_dl    = dlset_reg[idx] ? rd_data.deadline + {16'd0, rd_data.period}
                                      : time_reg + {16'd0, rd_data.period};
    assign s_tready  = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_comb
    begin
        free_idx = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        rd_addr = idx;
        wr_en   = 1'b0;
        wr_addr = idx;
        wr_data = rd_data;
        case (state_reg)
            S_EVAL:
            begin
                if (kind_reg == REQ_YIELD && hit && !found_reg)
                begin
                    wr_en = 1'b1;
                    wr_data.deadline = new_dl;
                    if (time_reg < new_dl)
                    begin
                        wr_data.run_state = RUN_SLEEPING;
                    end
                end
                else if (kind_reg == REQ_TICK && used_reg[idx] && dlset_reg[idx]
                         && rd_data.run_state == RUN_SLEEPING
                         && rd_data.deadline == time_reg)
                begin
                    wr_en = 1'b1;
                    wr_data.run_state = RUN_READY;
                end
            end
            S_DIVDONE:
            begin
                if (kind_reg == REQ_REGISTER)
                begin
                    wr_en   = admit;
                    wr_addr = best_reg;
                    wr_data.task_id   = id_reg;
                    wr_data.period    = per_reg;
                    wr_data.runtime   = rt_reg;
                    wr_data.deadline  = '0;
                    wr_data.run_state = RUN_SLEEPING;
                end
            end
            S_DEMRD:
            begin
                rd_addr = run_slot_reg;
            end
            S_DEMWR:
            begin
                wr_en   = (rd_data.run_state == RUN_RUNNING);
                wr_addr = run_slot_reg;
                wr_data.run_state = RUN_READY;
            end
            S_PRORD:
            begin
                rd_addr = best_reg;
            end
            S_PROWR:
            begin
                wr_en   = best_v_reg;
                wr_addr = best_reg;
                wr_data.run_state = RUN_RUNNING;
            end
            S_RREAD:
            begin
                rd_addr = run_slot_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            used_reg     <= '0;
            dlset_reg    <= '0;
            time_reg     <= '0;
            util_reg     <= '0;
            limit_reg    <= UTIL_LIMIT_RESET;
            run_p_reg    <= 1'b0;
            run_slot_reg <= '0;
            kind_reg     <= '0;
            id_reg       <= '0;
            per_reg      <= '0;
            rt_reg       <= '0;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            woke_reg     <= 1'b0;
            best_v_reg   <= 1'b0;
            best_reg     <= '0;
            best_per_reg <= '0;
            status_reg   <= STATUS_OK;
            num_reg      <= '0;
            rem_reg      <= '0;
            den_reg      <= '0;
            dcnt_reg     <= '0;
            m_valid_reg  <= 1'b0;
            m_data_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata[UTIL_W-1:0];
            end
            if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        kind_reg   <= s_tuser;
                        id_reg     <= s_tdata[ID_W-1:0];
                        per_reg    <= s_tdata[ID_W+PERIOD_W-1:ID_W];
                        rt_reg     <= s_tdata[ID_W+2*PERIOD_W-1:ID_W+PERIOD_W];
                        idx_reg    <= '0;
                        found_reg  <= 1'b0;
                        woke_reg   <= 1'b0;
                        best_v_reg <= 1'b0;
                        best_reg   <= '0;
                        status_reg <= STATUS_OK;
                        state_reg  <= S_PREP;
                        if (s_tuser == REQ_TICK)
                        begin
                            time_reg <= time_reg + DL_W'(1);
                        end
                    end
                end
                S_PREP:
                begin
                    if (kind_reg == REQ_REGISTER)
                    begin
                        best_reg <= free_idx;
                        if (per_reg == '0)
                        begin
                            status_reg <= STATUS_ZERO_PERIOD;
                            state_reg  <= S_RREAD;
                        end
                        else
                        begin
                            num_reg   <= NUM_W'(rt_reg) * NUM_W'(UTIL_SCALE);
                            den_reg   <= per_reg;
                            rem_reg   <= '0;
                            dcnt_reg  <= '0;
                            state_reg <= S_DIV;
                        end
                    end
                    else
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (kind_reg == REQ_YIELD && hit && !found_reg)
                    begin
                        found_reg <= 1'b1;
                        dlset_reg[idx] <= 1'b1;
                    end
                    if (wr_en && kind_reg == REQ_TICK)
                    begin
                        woke_reg <= 1'b1;
                    end
                    if (kind_reg == REQ_DEREGISTER && hit)
                    begin
                        found_reg <= 1'b1;
                        num_reg   <= NUM_W'(rd_data.runtime) * NUM_W'(UTIL_SCALE);
                        den_reg   <= rd_data.period;
                        rem_reg   <= '0;
                        dcnt_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                    else if (idx_reg == IDX_W'(MAX_TASKS - 1))
                    begin
                        idx_reg <= '0;
                        if (kind_reg == REQ_YIELD && !found_reg && !hit)
                        begin
                            status_reg <= STATUS_NOT_FOUND;
                            state_reg  <= S_RREAD;
                        end
                        else if (kind_reg == REQ_DEREGISTER)
                        begin
                            if (!found_reg)
                            begin
                                status_reg <= STATUS_NOT_FOUND;
                            end
                            state_reg <= S_RREAD;
                        end
                        else if (kind_reg == REQ_YIELD || woke_reg || wr_en)
                        begin
                            state_reg <= S_DREAD;
                        end
                        else
                        begin
                            state_reg <= S_RREAD;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IDX_W'(1);
                        state_reg <= S_READ;
                    end
                end
                S_DIV:
                begin
                    num_reg <= {num_reg[NUM_W-2:0], ~trial[PERIOD_W]};
                    rem_reg <= trial[PERIOD_W] ?
                               {rem_reg[PERIOD_W-1:0], num_reg[NUM_W-1]} : trial;
                    dcnt_reg <= dcnt_reg + 5'd1;
                    if (dcnt_reg == 5'(NUM_W - 1))
                    begin
                        state_reg <= S_DIVDONE;
                    end
                end
                S_DIVDONE:
                begin
                    if (kind_reg == REQ_REGISTER)
                    begin
                        if (share_big || sum_ext > {2'b00, limit_reg})
                        begin
                            status_reg <= STATUS_REFUSED;
                        end
                        else if (&used_reg)
                        begin
                            status_reg <= STATUS_TABLE_FULL;
                        end
                        else
                        begin
                            util_reg <= sum_ext[UTIL_W-1:0];
                            used_reg[best_reg]  <= 1'b1;
                            dlset_reg[best_reg] <= 1'b0;
                        end
                        state_reg <= S_RREAD;
                    end
                    else
                    begin
                        util_reg <= (share_big || share >= {1'b0, util_reg}) ? '0
                                    : util_reg - share[UTIL_W-1:0];
                        used_reg[idx]  <= 1'b0;
                        dlset_reg[idx] <= 1'b0;
                        if (run_p_reg && run_slot_reg == idx)
                        begin
                            run_p_reg    <= 1'b0;
                            run_slot_reg <= '0;
                        end
                        if (idx_reg == IDX_W'(MAX_TASKS - 1))
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_RREAD;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + IDX_W'(1);
                            state_reg <= S_READ;
                        end
                    end
                end
                S_DREAD:
                begin
                    state_reg <= S_DEVAL;
                end
                S_DEVAL:
                begin
                    if (used_reg[idx] && (rd_data.run_state == RUN_READY
                        || rd_data.run_state == RUN_RUNNING)
                        && (!best_v_reg || rd_data.period < best_per_reg))
                    begin
                        best_v_reg   <= 1'b1;
                        best_reg     <= idx;
                        best_per_reg <= rd_data.period;
                    end
                    if (idx_reg == IDX_W'(MAX_TASKS - 1))
                    begin
                        idx_reg   <= '0;
                        state_reg <= run_p_reg ? S_DEMRD : S_PRORD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IDX_W'(1);
                        state_reg <= S_DREAD;
                    end
                end
                S_DEMRD:
                begin
                    state_reg <= S_DEMWR;
                end
                S_DEMWR:
                begin
                    run_p_reg    <= 1'b0;
                    run_slot_reg <= '0;
                    state_reg    <= S_PRORD;
                end
                S_PRORD:
                begin
                    state_reg <= S_PROWR;
                end
                S_PROWR:
                begin
                    if (best_v_reg)
                    begin
                        run_p_reg    <= 1'b1;
                        run_slot_reg <= best_reg;
                    end
                    state_reg <= S_RREAD;
                end
                S_RREAD:
                begin
                    state_reg <= S_RESULT;
                end
                S_RESULT:
                begin
                    m_valid_reg <= 1'b1;
                    m_data_reg  <= {4'b0000, util_reg,
                                    run_p_reg ? rd_data.task_id : ID_W'(0),
                                    run_p_reg, status_reg};
                    state_reg   <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/rmts_checker.sv =====
`include "assert_macros.svh"

module rmts_assert
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ASSERT_IMPL(a_status_range, clk, rst_n, m_tvalid, m_tdata[2:0] <= 3'd4)
    `ASSERT_IMPL(a_idle_id, clk, rst_n, m_tvalid && !m_tdata[3], m_tdata[25:4] == 22'd0)
    `ASSERT_NEXT(a_one_busy, clk, rst_n, s_tvalid && s_tready, !s_tready)

endmodule

bind rate_monotonic_task_scheduler rmts_assert u_rmts_assert
(
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
